### hdl/fpba_pkg.sv
package fpba_pkg;

    // Fixed field widths of the stream items.
    localparam int BLK_W      = 3;
    localparam int AMT_W      = 16;
    localparam int TDATA_W    = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam int ACTIVE_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 4'd1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2,
        MODE_NEXT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESULT
    } t_state;

    // Verdict of the shared comparator on one candidate block.
    typedef struct packed {
        logic fits;
        logic take;
    } t_cmp_res;

endpackage

### hdl/fpba_mem.sv
module fpba_mem #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_waddr,
    input  logic [SIZE_BITS-1:0]          i_wdata,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_raddr,
    output logic [SIZE_BITS-1:0]          o_rdata
);
    import fpba_pkg::*;

    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [SIZE_BITS-1:0]  r_rdata;
    logic                  r_rd_ok;

    // An entry never written since reset reads as an empty block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
        r_rd_ok <= r_vld[i_raddr];
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

### hdl/fpba_cmp.sv
module fpba_cmp #(
    parameter int SIZE_BITS = 16
) (
    input  fpba_pkg::t_mode       i_mode,
    input  logic [SIZE_BITS-1:0]  i_cand,
    input  logic [SIZE_BITS-1:0]  i_want,
    input  logic [SIZE_BITS-1:0]  i_best,
    input  logic                  i_have,
    output fpba_pkg::t_cmp_res    o_res
);
    import fpba_pkg::*;

    logic fits;
    logic better;

    always_comb begin
        fits   = (i_cand >= i_want);
        better = 1'b0;
        case (i_mode)
            MODE_BEST:  better = (i_cand < i_best);
            MODE_WORST: better = (i_cand > i_best);
            default:    better = 1'b0;
        endcase
        // Strict comparisons keep ties on the lower index.
        o_res.fits = fits;
        o_res.take = fits && (!i_have || better);
    end

endmodule

### hdl/fit_policy_block_allocator.sv
// Block allocator with first, best, worst and next fit placement. A load
// request writes one block's free size and returns a zero result through
// the result state and the output register. A placement request scans the
// active blocks one per cycle through a single read port and one shared
// comparator. Each read's data is judged in the cycle after it is issued,
// and first and next fit stop as soon as a block that fits has been judged.
// A grant then passes through the update state, and the result state moves
// the result into the output register. The input is ready only while the
// sequencer is idle. A result may wait in the output register while the
// next request is taken, but a later result stays in the sequencer until
// that register is free.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [2:0] block_number, [18:3] amount, [23:19] zero
    input  logic [fpba_pkg::TDATA_W-1:0]       i_s_axis_tdata,
    // [0] operation
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [2:0] chosen_block, [18:3] remaining_after, [23:19] zero
    output logic [fpba_pkg::TDATA_W-1:0]       o_m_axis_tdata,
    // [0] granted
    output logic [0:0]                         o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int NMAX  = (NUM_BLOCKS < 15) ? NUM_BLOCKS : 15;
    localparam int CNT_W = $clog2(NMAX + 1);
    localparam logic [31:0] NB32 = NUM_BLOCKS;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [ACTIVE_W-1:0]   r_active, n_active;
    logic [IDX_W-1:0]      r_next, n_next;
    logic [SIZE_BITS-1:0]  r_want, n_want;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [CNT_W-1:0]      r_iss, n_iss;
    logic [IDX_W-1:0]      r_addr, n_addr;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic                  r_have, n_have;
    logic [SIZE_BITS-1:0]  r_best, n_best;
    logic [IDX_W-1:0]      r_bidx, n_bidx;
    logic                  r_res_grant, n_res_grant;
    logic [BLK_W-1:0]      r_res_blk, n_res_blk;
    logic [AMT_W-1:0]      r_res_rem, n_res_rem;
    logic                  r_out_vld, n_out_vld;
    logic                  r_out_grant, n_out_grant;
    logic [BLK_W-1:0]      r_out_blk, n_out_blk;
    logic [AMT_W-1:0]      r_out_rem, n_out_rem;

    logic                  in_acc;
    logic [BLK_W-1:0]      in_blk;
    logic [SIZE_BITS-1:0]  in_amt;
    logic                  blk_ok;
    logic [CNT_W-1:0]      cnt;
    logic [IDX_W-1:0]      start;
    logic [31:0]           addr_inc;
    logic [SIZE_BITS-1:0]  diff;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [SIZE_BITS-1:0]  mem_wdata;
    logic [SIZE_BITS-1:0]  rd_data;
    t_cmp_res              cmp;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_blk = i_s_axis_tdata[BLK_W-1:0];
    assign in_amt = SIZE_BITS'(i_s_axis_tdata[BLK_W +: AMT_W]);
    assign blk_ok = ({29'd0, in_blk} < NB32);

    // Values above the block count act as the block count.
    assign cnt = ({28'd0, r_active} > NB32) ? CNT_W'(NMAX) : CNT_W'(r_active);
    assign start = ((r_mode == MODE_NEXT) && (32'(r_next) < 32'(cnt))) ? r_next : '0;
    assign addr_inc = 32'(r_addr) + 32'd1;
    assign diff = r_best - r_want;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_grant;
    assign o_m_axis_tdata  = {{(TDATA_W - BLK_W - AMT_W){1'b0}}, r_out_rem, r_out_blk};

    fpba_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    fpba_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .i_mode (r_mode),
        .i_cand (rd_data),
        .i_want (r_want),
        .i_best (r_best),
        .i_have (r_have),
        .o_res  (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_FIRST;
            r_active  <= ACTIVE_RESET;
            r_next    <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_have    <= 1'b0;
            r_iss     <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_active  <= n_active;
            r_next    <= n_next;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
            r_have    <= n_have;
            r_iss     <= n_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want      <= n_want;
        r_n         <= n_n;
        r_addr      <= n_addr;
        r_pidx      <= n_pidx;
        r_best      <= n_best;
        r_bidx      <= n_bidx;
        r_res_grant <= n_res_grant;
        r_res_blk   <= n_res_blk;
        r_res_rem   <= n_res_rem;
        r_out_grant <= n_out_grant;
        r_out_blk   <= n_out_blk;
        r_out_rem   <= n_out_rem;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_active    = r_active;
        n_next      = r_next;
        n_want      = r_want;
        n_n         = r_n;
        n_iss       = r_iss;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_have      = r_have;
        n_best      = r_best;
        n_bidx      = r_bidx;
        n_res_grant = r_res_grant;
        n_res_blk   = r_res_blk;
        n_res_rem   = r_res_rem;
        n_out_vld   = r_out_vld;
        n_out_grant = r_out_grant;
        n_out_blk   = r_out_blk;
        n_out_rem   = r_out_rem;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MODE) begin
                n_mode = t_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_index == CFG_ACTIVE) begin
                n_active = i_cfg_data;
            end
        end

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_grant = 1'b0;
                    n_res_blk   = '0;
                    n_res_rem   = '0;
                    if (i_s_axis_tuser[0] == OP_LOAD) begin
                        mem_we    = blk_ok;
                        mem_waddr = IDX_W'(in_blk);
                        mem_wdata = in_amt;
                        n_next    = '0;
                        n_state   = S_RESULT;
                    end else begin
                        n_want = in_amt;
                        n_n    = cnt;
                        n_iss  = '0;
                        n_pend = 1'b0;
                        n_have = 1'b0;
                        n_addr = start;
                        n_state = (cnt == '0) ? S_RESULT : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle; its data is judged in the next cycle.
                if (r_iss != r_n) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    n_addr = (addr_inc == 32'(r_n)) ? '0 : IDX_W'(addr_inc);
                    n_iss  = r_iss + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && cmp.take) begin
                    n_have = 1'b1;
                    n_best = rd_data;
                    n_bidx = r_pidx;
                    if (r_mode == MODE_FIRST || r_mode == MODE_NEXT) begin
                        n_state = S_UPDATE;
                    end
                end else if (!r_pend && r_iss == r_n) begin
                    n_state = r_have ? S_UPDATE : S_RESULT;
                end
            end
            S_UPDATE: begin
                mem_we      = 1'b1;
                mem_waddr   = r_bidx;
                mem_wdata   = diff;
                n_next      = r_bidx;
                n_res_grant = 1'b1;
                n_res_blk   = BLK_W'(r_bidx);
                n_res_rem   = AMT_W'(diff);
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_grant = r_res_grant;
                    n_out_blk   = r_res_blk;
                    n_out_rem   = r_res_rem;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("input accepted while a request is still in progress");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_iss <= r_n))
        else $error("scan issued more reads than active blocks");

    a_grant_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (32'(r_bidx) < 32'(r_n)))
        else $error("granted block lies outside the active blocks");

    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_grant) |-> (r_out_blk == '0 && r_out_rem == '0))
        else $error("result without a grant carries non-zero data");
`endif

endmodule
